FILE: sv/fia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fia_pkg: shared types and constants for the floored integer ALU
// Opcodes, status codes, transfer structs and pipeline sizing.
// ----------------------------------------------------------------------------
package fia_pkg;

   localparam int DataWidth = 64;
   localparam int MagWidth  = 64;
   // divider retires this many quotient bits per stage
   localparam int BitsPerStage = 4;
   localparam int DivStages    = MagWidth / BitsPerStage;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_IDIV = 4'd3,
      OP_MOD  = 4'd4,
      OP_AND  = 4'd5,
      OP_OR   = 4'd6,
      OP_XOR  = 4'd7,
      OP_SHL  = 4'd8,
      OP_SHR  = 4'd9,
      OP_EQ   = 4'd10,
      OP_LT   = 4'd11,
      OP_LE   = 4'd12,
      OP_R13  = 4'd13,
      OP_R14  = 4'd14,
      OP_R15  = 4'd15
   } op_type;

   typedef enum logic [1:0] {
      ST_INT  = 2'd0,
      ST_BOOL = 2'd1,
      ST_DIVZ = 2'd2,
      ST_RSVD = 2'd3
   } status_type;

   typedef struct packed {
      logic [3:0]                   operation;
      logic signed [DataWidth-1:0] operand_a;
      logic signed [DataWidth-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] value;
      logic [1:0]                   status;
   } rsp_type;

   // fixups the divider output needs
   typedef struct packed {
      logic is_mod;
      logic divz;
      logic neg_one;
      logic neg_a;
      logic neg_b;
   } div_ctl_type;

endpackage

FILE: sv/fia_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fia_mul: pipelined 64x64 wrapping multiplier
// Three 32x32 partial products, registered side by side, then sum.
// Latency matches the divider plus its alignment register in the top level so results line up.
// ----------------------------------------------------------------------------
module fia_mul
   import fia_pkg::*;
(
   input  logic                 clock,
   input  logic [DataWidth-1:0] a_in,
   input  logic [DataWidth-1:0] b_in,
   output logic [DataWidth-1:0] prod_out
);

   logic [63:0] ll_ff, lh_ff, hl_ff;
   logic [63:0] ll_in, lh_in, hl_in;
   logic [63:0] sum_ff, sum_in;
   logic [63:0] dly_ff [DivStages-1];

   assign ll_in = 64'(a_in[31:0]) * 64'(b_in[31:0]);
   assign lh_in = 64'(a_in[31:0]) * 64'(b_in[63:32]);
   assign hl_in = 64'(a_in[63:32]) * 64'(b_in[31:0]);
   assign sum_in = ll_ff + {lh_ff[31:0] + hl_ff[31:0], 32'd0};

   always_ff @(posedge clock) begin
      ll_ff  <= ll_in;
      lh_ff  <= lh_in;
      hl_ff  <= hl_in;
      sum_ff <= sum_in;
      dly_ff[0] <= sum_ff;
      for (int i = 1; i < DivStages - 1; i++) begin
         dly_ff[i] <= dly_ff[i-1];
      end
   end

   // output follows the partial-product, sum and delay-line registers
   assign prod_out = dly_ff[DivStages-2];

endmodule

FILE: sv/fia_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fia_div: pipelined unsigned restoring divider
// Magnitudes in, BitsPerStage quotient bits per stage, remainder out.
// ----------------------------------------------------------------------------
module fia_div
   import fia_pkg::*;
(
   input  logic                clock,
   input  logic [MagWidth-1:0] num_in,
   input  logic [MagWidth-1:0] den_in,
   output logic [MagWidth-1:0] quo_out,
   output logic [MagWidth-1:0] rem_out
);

   logic [MagWidth-1:0] num_ff [DivStages];
   logic [MagWidth-1:0] den_ff [DivStages];
   logic [MagWidth-1:0] rem_ff [DivStages];

   always_ff @(posedge clock) begin
      for (int s = 0; s < DivStages; s++) begin
         logic [MagWidth-1:0] n, d, q;
         logic [MagWidth:0]   r;
         if (s == 0) begin
            n = num_in;
            d = den_in;
            r = '0;
         end else begin
            n = num_ff[s-1];
            d = den_ff[s-1];
            r = {1'b0, rem_ff[s-1]};
         end
         q = n;
         for (int k = 0; k < BitsPerStage; k++) begin
            r = {r[MagWidth-1:0], q[MagWidth-1]};
            q = {q[MagWidth-2:0], 1'b0};
            if (r >= {1'b0, d}) begin
               r    = r - {1'b0, d};
               q[0] = 1'b1;
            end
         end
         num_ff[s] <= q;
         den_ff[s] <= d;
         rem_ff[s] <= r[MagWidth-1:0];
      end
   end

   assign quo_out = num_ff[DivStages-1];
   assign rem_out = rem_ff[DivStages-1];

endmodule

FILE: sv/floored_integer_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floored_integer_alu: 64-bit integer ALU with floored divide and modulo
// Wrapping add/sub/mul, floored idiv/mod, bitwise ops, two-way logical
// shift and signed compares, fully pipelined.
// ----------------------------------------------------------------------------
//
//   channel  | ports                          | transfer when
//   ---------+--------------------------------+-------------------------
//   request  | start, busy, req_data          | start && !busy
//   response | rsp_valid, rsp_data            | rsp_valid (one cycle)
//
// One item per cycle; each item passes the input stage, the divider pipeline
// (4 quotient bits/stage), the alignment and output registers from start to rsp_valid.
// busy is always low: the receiver cannot stall, so nothing waits.
// Synchronous reset clears the valid chain only; data registers free-run.
//
module floored_integer_alu
   import fia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int Lat = DivStages + 1; // depth of the side-band delay line after input stage

   // ---- stage 0: capture the request ----
   logic    v0_ff;
   req_type r0_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start;
      end
      r0_ff <= req_data;
   end

   logic [63:0] ua, ub;
   op_type      op;
   assign ua = r0_ff.operand_a;
   assign ub = r0_ff.operand_b;
   assign op = op_type'(r0_ff.operation);

   // ---- simple ops, computed now, delayed to line up ----
   logic [63:0] shamt_neg, sh_y, simple_val;
   logic [1:0]  simple_st;
   logic        sh_left;
   logic [63:0] sh_mag;

   always_comb begin
      shamt_neg = 64'd0 - ub;
      sh_y      = (op == OP_SHR) ? shamt_neg : ub;
      sh_left   = ~sh_y[63];
      sh_mag    = sh_y[63] ? (64'd0 - sh_y) : sh_y;
      simple_val = '0;
      simple_st  = ST_INT;
      unique case (op)
         OP_ADD: simple_val = ua + ub;
         OP_SUB: simple_val = ua - ub;
         OP_AND: simple_val = ua & ub;
         OP_OR:  simple_val = ua | ub;
         OP_XOR: simple_val = ua ^ ub;
         OP_SHL, OP_SHR: begin
            // most negative amount negates to itself: magnitude >= 64
            if (sh_mag >= 64'd64 || sh_y == 64'h8000_0000_0000_0000) begin
               simple_val = '0;
            end else if (sh_left) begin
               simple_val = ua << sh_mag[5:0];
            end else begin
               simple_val = ua >> sh_mag[5:0];
            end
         end
         OP_EQ: begin
            simple_val = {63'd0, ua == ub};
            simple_st  = ST_BOOL;
         end
         OP_LT: begin
            simple_val = {63'd0, $signed(ua) < $signed(ub)};
            simple_st  = ST_BOOL;
         end
         OP_LE: begin
            simple_val = {63'd0, $signed(ua) <= $signed(ub)};
            simple_st  = ST_BOOL;
         end
         OP_MUL, OP_IDIV, OP_MOD, OP_R13, OP_R14, OP_R15: begin
            simple_val = '0;
         end
      endcase
   end

   // ---- divider and multiplier ----
   logic [63:0] mag_a, mag_b, quo, rem, prod;
   assign mag_a = ua[63] ? (64'd0 - ua) : ua;
   assign mag_b = ub[63] ? (64'd0 - ub) : ub;

   fia_div u_div (
      .clock  (clock),
      .num_in (mag_a),
      .den_in (mag_b),
      .quo_out(quo),
      .rem_out(rem)
   );

   fia_mul u_mul (
      .clock   (clock),
      .a_in    (ua),
      .b_in    (ub),
      .prod_out(prod)
   );

   // ---- side-band delay line: valid, op class, simple result, fixups ----
   typedef struct packed {
      logic        valid;
      logic        is_mul;
      logic        is_div;
      div_ctl_type dc;
      logic [63:0] nega;   // wrapped -a for divisor of -1
      logic [63:0] b;
      logic [63:0] sval;
      logic [1:0]  sst;
   } side_type;

   side_type side_in;
   side_type side_ff [Lat];

   always_comb begin
      side_in.valid      = v0_ff;
      side_in.is_mul     = (op == OP_MUL);
      side_in.is_div     = (op == OP_IDIV) || (op == OP_MOD);
      side_in.dc.is_mod  = (op == OP_MOD);
      side_in.dc.divz    = (ub == 64'd0);
      side_in.dc.neg_one = (ub == '1);
      side_in.dc.neg_a   = ua[63];
      side_in.dc.neg_b   = ub[63];
      side_in.nega       = 64'd0 - ua;
      side_in.b          = ub;
      side_in.sval       = simple_val;
      side_in.sst        = simple_st;
   end

   always_ff @(posedge clock) begin
      side_type nxt;
      nxt       = side_in;
      nxt.valid = side_in.valid & ~reset;
      side_ff[0] <= nxt;
      for (int i = 1; i < Lat; i++) begin
         nxt       = side_ff[i-1];
         nxt.valid = side_ff[i-1].valid & ~reset;
         side_ff[i] <= nxt;
      end
   end

   // align the divider output with the side-band delay line via one extra register
   logic [63:0] quo_ff, rem_ff;
   always_ff @(posedge clock) begin
      quo_ff <= quo;
      rem_ff <= rem;
   end

   // ---- final stage: floored fixup and select ----
   side_type    sd;
   logic [63:0] tq, tr, fl_q, fl_r, out_val;
   logic [1:0]  out_st;
   logic        sdiff;

   assign sd = side_ff[Lat-1];

   always_comb begin
      sdiff = sd.dc.neg_a ^ sd.dc.neg_b;
      // truncated results from magnitudes
      tq = sdiff ? (64'd0 - quo_ff) : quo_ff;
      tr = sd.dc.neg_a ? (64'd0 - rem_ff) : rem_ff;
      fl_q = (sdiff && rem_ff != 64'd0) ? (tq - 64'd1) : tq;
      fl_r = (sdiff && rem_ff != 64'd0) ? (tr + sd.b) : tr;
      out_val = sd.sval;
      out_st  = sd.sst;
      if (sd.is_mul) begin
         out_val = prod;
      end else if (sd.is_div) begin
         if (sd.dc.divz) begin
            out_val = '0;
            out_st  = ST_DIVZ;
         end else if (sd.dc.neg_one) begin
            out_val = sd.dc.is_mod ? 64'd0 : sd.nega;
         end else begin
            out_val = sd.dc.is_mod ? fl_r : fl_q;
         end
      end
   end

   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sd.valid;
      end
      rsp_ff <= '{value: out_val, status: out_st};
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- assertions ----
   a_valid_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(Lat+2) rsp_valid)
      else $error("response did not follow request at fixed latency");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, Lat+2))
      else $error("response without a request");

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_DIVZ |-> rsp_data.value == '0)
      else $error("divide by zero with nonzero value");

   a_bool_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_BOOL |-> rsp_data.value[63:1] == '0)
      else $error("boolean result wider than one bit");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the floored integer ALU
// Directed corner cases, then random opcodes and operands across several
// idle phases; every response transfer is checked against a local predictor.
// ----------------------------------------------------------------------------

class alu_scoreboard;
   fia_pkg::rsp_type pending[$];
   int               errors;

   function new();
      errors = 0;
   endfunction

   // floored integer ALU behavior, computed at 64 bits
   function fia_pkg::rsp_type compute(fia_pkg::req_type r);
      fia_pkg::rsp_type  o;
      logic signed [63:0] a, b, q, m;
      logic [63:0]        amt;
      a = r.operand_a;
      b = r.operand_b;
      o.value  = '0;
      o.status = fia_pkg::ST_INT;
      case (fia_pkg::op_type'(r.operation))
         fia_pkg::OP_ADD: o.value = a + b;
         fia_pkg::OP_SUB: o.value = a - b;
         fia_pkg::OP_MUL: o.value = a * b;
         fia_pkg::OP_IDIV, fia_pkg::OP_MOD: begin
            if (b == 0) begin
               o.status = fia_pkg::ST_DIVZ;
            end else if (b == -64'sd1) begin
               o.value = (r.operation == fia_pkg::OP_IDIV) ? -a : 64'sd0;
            end else begin
               q = a / b;
               m = a % b;
               if (m != 0 && ((m < 0) != (b < 0))) begin
                  q = q - 1;
                  m = m + b;
               end
               o.value = (r.operation == fia_pkg::OP_IDIV) ? q : m;
            end
         end
         fia_pkg::OP_AND: o.value = a & b;
         fia_pkg::OP_OR:  o.value = a | b;
         fia_pkg::OP_XOR: o.value = a ^ b;
         fia_pkg::OP_SHL, fia_pkg::OP_SHR: begin
            amt = (r.operation == fia_pkg::OP_SHR) ? -b : b;
            if ($signed(amt) < 0) begin
               o.value = ($signed(amt) <= -64) ? 64'd0 : (a >> (-amt));
            end else begin
               o.value = ($signed(amt) >= 64) ? 64'd0 : (a << amt);
            end
         end
         fia_pkg::OP_EQ: begin
            o.value = 64'(a == b); o.status = fia_pkg::ST_BOOL;
         end
         fia_pkg::OP_LT: begin
            o.value = 64'(a < b); o.status = fia_pkg::ST_BOOL;
         end
         fia_pkg::OP_LE: begin
            o.value = 64'(a <= b); o.status = fia_pkg::ST_BOOL;
         end
         default: ;
      endcase
      return o;
   endfunction

   function void note_request(fia_pkg::req_type r);
      pending.push_back(compute(r));
   endfunction

   function void check_response(fia_pkg::rsp_type got);
      fia_pkg::rsp_type want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response value=%h status=%0d",
                  $time, got.value, got.status);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.value !== want.value) begin
         $display("%0t: value mismatch expected %h actual %h", $time, want.value, got.value);
         errors++;
      end
      if (got.status !== want.status) begin
         $display("%0t: status mismatch expected %0d actual %0d",
                  $time, want.status, got.status);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import fia_pkg::*;

   localparam int Latency  = DivStages + 3;
   localparam int MaxCycles = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   alu_scoreboard board = new();
   int            send_idle_pct = 0;
   int            cycle_count = 0;

   floored_integer_alu DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: a transfer is any cycle with rsp_valid high
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) board.check_response(rsp_data);
      if (cycle_count > MaxCycles) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // random idle cycles on the request side, then one transfer
   task automatic send(input logic [3:0] op, input logic [63:0] a, input logic [63:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= '{operation: op, operand_a: a, operand_b: b};
      // accept at the next rising edge when busy is low
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request('{operation: op, operand_a: a, operand_b: b});
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   function automatic logic [63:0] pick_operand();
      case ($urandom_range(7))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7fff_ffff_ffff_ffff;
         2: return {64{1'b1}};
         3: return 64'd0;
         4: return 64'($signed($urandom_range(140)) - 70);   // near shift edges
         5: return 64'($signed({1'b0, $urandom_range(2000)}) - 1000);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   logic [63:0] vals [6];
   int          ph;

   initial begin
      vals = '{64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, {64{1'b1}},
               64'd0, 64'd1, 64'd64};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every opcode with extreme operands, plus the special cases
      send(OP_IDIV, 64'd7, 64'd0);                        // divide by zero
      send(OP_MOD, 64'h8000_0000_0000_0000, 64'd0);
      send(OP_IDIV, 64'h8000_0000_0000_0000, {64{1'b1}}); // min / -1 wraps
      send(OP_MOD, 64'h8000_0000_0000_0000, {64{1'b1}});
      send(OP_IDIV, -64'sd7, 64'd2);
      send(OP_MOD, -64'sd7, 64'd2);
      send(OP_MOD, 64'd7, -64'sd2);
      send(OP_SHR, {64{1'b1}}, 64'h8000_0000_0000_0000); // most negative amount
      send(OP_SHL, {64{1'b1}}, 64'h8000_0000_0000_0000);
      send(OP_SHL, {64{1'b1}}, -64'sd63);
      send(OP_SHL, {64{1'b1}}, 64'd63);
      send(OP_SHL, {64{1'b1}}, 64'd64);
      send(OP_SHR, {64{1'b1}}, -64'sd64);
      for (int k = 0; k < 16; k++) send(4'(k), vals[k % 6], vals[(k + 1) % 6]);
      drain();

      // random phases: no idle, 80% idle, 11% idle, then no idle with a pause midway
      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 80 : (ph == 2) ? 11 : 0;
         for (int n = 0; n < 440; n++) begin
            send(4'($urandom_range(15)), pick_operand(), pick_operand());
            if (ph == 3 && n == 200) drain();   // pause until all responses arrive
         end
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

FILE: files.f
sv/fia_pkg.sv
sv/fia_mul.sv
sv/fia_div.sv
sv/floored_integer_alu.sv
test/tb_top.sv
